/* src/vpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types and constants for the video packet deframer.
// ----------------------------------------------------------------------------
package vpd_pkg;

  localparam int unsigned HdrBytes    = 12;
  localparam int unsigned StoreBits   = (HdrBytes - 1) * 8;
  localparam int unsigned HdrBits     = HdrBytes * 8;
  localparam int unsigned TsBits      = 61;
  localparam int unsigned SizeBits    = 32;
  localparam int unsigned TdataBits   = 136;
  localparam int unsigned TuserBits   = 3;

  // Bit positions inside the 64-bit PTS word.
  localparam int unsigned CfgFlagBit  = 62;
  localparam int unsigned KeyFlagBit  = 61;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_SESSION = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_HALT    = 3'b100
  } phase_e;

  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            data_byte;
    logic                  first_of_packet;
    logic                  last_of_packet;
    logic [TsBits-1:0]     timestamp;
    logic                  config_packet;
    logic                  is_key_frame;
    logic [SizeBits-1:0]   frame_width;
    logic [SizeBits-1:0]   frame_height;
  } result_t;

endpackage

/* src/video_packet_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_packet_deframer
// Splits a link byte stream into 12-byte headers and tagged payload bytes.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata[7:0] link byte
//  m_axis    out  tuser = kind, first; tlast = last payload byte;
//                 tdata = byte, timestamp, flags, width, height
//
//  One byte per cycle sustained while the output is not stalled: input
//  register, one step of header/payload logic, result register. Reset
//  (rst_ni low, async) returns to header collection and drops both
//  registers. A stalled output holds the result; one more byte may still be
//  taken into the input register, after which s_axis_tready_o drops.
//  A zero-length header halts the block until reset; bytes are then taken
//  and dropped.
// ----------------------------------------------------------------------------
module video_packet_deframer import vpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // link bytes
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] stream_byte
  // results
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] data_byte, [68:8] timestamp, [69] config_packet, [70] is_key_frame,
  // [102:71] frame_width, [134:103] frame_height, [135] zero
  output logic [TdataBits-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o,   // last_of_packet
  output logic [TuserBits-1:0] m_axis_tuser_o    // [1:0] event_kind, [2] first_of_packet
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       step;
  logic       res_valid;
  result_t    res_next;
  result_t    res_out;

  // The core advances whenever a byte is held and the result register is
  // free, whether or not this byte yields a result.
  assign step = held_valid && out_free;

  vpd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .take_i       (step),
    .held_valid_o (held_valid),
    .held_byte_o  (held_byte)
  );

  vpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (held_byte),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  vpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_valid),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res_out)
  );

  // Pack result fields onto the stream, lowest field first.
  assign m_axis_tdata_o = {1'b0,
                           res_out.frame_height,
                           res_out.frame_width,
                           res_out.is_key_frame,
                           res_out.config_packet,
                           res_out.timestamp,
                           res_out.data_byte};
  assign m_axis_tlast_o = res_out.last_of_packet;
  assign m_axis_tuser_o = {res_out.first_of_packet, res_out.kind};

endmodule

/* src/vpd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_in_stage
// Input register for link bytes; frees itself as the core consumes it.
// ----------------------------------------------------------------------------
module vpd_in_stage import vpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       take_i,      // core consumes the held byte this cycle
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o   = !valid_q || take_i;
  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

/* src/vpd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_core
// Header collection, payload tagging and halt state; one byte per step.
// ----------------------------------------------------------------------------
module vpd_core import vpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e                phase_q, phase_d;
  logic [3:0]            count_q, count_d;
  logic [StoreBits-1:0]  store_q;
  logic [31:0]           left_q, left_d;
  logic [TsBits-1:0]     ts_q, ts_d;
  logic                  cfg_q, cfg_d;
  logic                  key_q, key_d;
  logic                  first_q, first_d;

  logic [HdrBits-1:0]    hdr;
  logic [31:0]           len;
  logic                  collecting;
  logic                  last_byte;

  // Byte 0 of the header sits in the top bits.
  assign hdr        = {store_q, byte_i};
  assign len        = hdr[31:0];
  assign collecting = (phase_q == PH_HEADER) && (count_q < 4'(HdrBytes - 1));
  assign last_byte  = (left_q[31:1] == '0);

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    left_d      = left_q;
    ts_d        = ts_q;
    cfg_d       = cfg_q;
    key_d       = key_q;
    first_d     = first_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_PAYLOAD;

    case (phase_q)
      PH_HEADER: begin
        if (collecting) begin
          count_d = count_q + 4'd1;
        end else begin
          count_d = '0;
          if (hdr[HdrBits-1]) begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_SESSION;
            res_o.frame_width  = hdr[63:32];
            res_o.frame_height = hdr[31:0];
          end else if (len == '0) begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
            phase_d     = PH_HALT;
          end else begin
            cfg_d   = hdr[32 + CfgFlagBit];
            key_d   = hdr[32 + KeyFlagBit];
            ts_d    = hdr[32 + CfgFlagBit] ? '0 : hdr[32 +: TsBits];
            left_d  = len;
            first_d = 1'b1;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid_o           = 1'b1;
        res_o.data_byte       = byte_i;
        res_o.first_of_packet = first_q;
        res_o.last_of_packet  = last_byte;
        res_o.timestamp       = ts_q;
        res_o.config_packet   = cfg_q;
        res_o.is_key_frame    = key_q;
        first_d               = 1'b0;
        if (last_byte) begin
          left_d  = '0;
          count_d = '0;
          phase_d = PH_HEADER;
        end else begin
          left_d = left_q - 32'd1;
        end
      end
      default: begin
        // halted: bytes are dropped until reset
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      count_q <= '0;
      left_q  <= '0;
      ts_q    <= '0;
      cfg_q   <= 1'b0;
      key_q   <= 1'b0;
      first_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      left_q  <= left_d;
      ts_q    <= ts_d;
      cfg_q   <= cfg_d;
      key_q   <= key_d;
      first_q <= first_d;
    end
  end

  // Header bytes shift in; only the first eleven are kept.
  always_ff @(posedge clk_i) begin
    if (step_i && collecting) begin
      store_q <= {store_q[StoreBits-9:0], byte_i};
    end
  end

endmodule

/* src/vpd_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_out_stage
// Result register facing the output stream.
// ----------------------------------------------------------------------------
module vpd_out_stage import vpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,     // register can take a result this cycle
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* sim/video_packet_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_packet_deframer_tb
// Self-checking bench for the link byte deframer. Headers and payloads are
// built as byte streams and sent one transfer at a time, with random gaps on
// the link side and random stalls on the result side. Every accepted byte is
// run through a behavioral deframer, and the events that it predicts are
// compared field by field with the results. The zero-length error halts the
// block for good, so it is tested last.
// ----------------------------------------------------------------------------
module video_packet_deframer_tb;
  import vpd_pkg::*;

  localparam int unsigned RandomBytes = 700;
  localparam int unsigned SteadyBytes = 100;  // tail of the random part, no idling

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TdataBits-1:0] m_tdata;
  logic                 m_tlast;
  logic [TuserBits-1:0] m_tuser;

  // Behavioral deframer state
  phase_e               ph = PH_HEADER;
  int unsigned          hdr_cnt = 0;
  logic [StoreBits-1:0] hdr_shift = '0;   // oldest header byte at the top
  logic [31:0]          bytes_left = '0;
  logic [TsBits-1:0]    held_ts = '0;
  logic                 held_cfg = 1'b0;
  logic                 held_key = 1'b0;
  logic                 first_pending = 1'b0;

  result_t              expected_events[$];
  int unsigned          mismatches = 0;
  int unsigned          bytes_sent = 0;
  bit                   steady = 1'b0;    // set: neither side idles

  video_packet_deframer i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction: one accepted link byte in, zero or one event out.
  // --------------------------------------------------------------------------
  function automatic void deframe_byte(input logic [7:0] b);
    logic [HdrBits-1:0] hdr;
    logic [63:0]        pts_word;
    logic [31:0]        len;
    result_t            ev;
    ev = '0;
    case (ph)
      PH_HEADER: begin
        if (hdr_cnt < HdrBytes - 1) begin
          hdr_shift = {hdr_shift[StoreBits-9:0], b};
          hdr_cnt++;
        end else begin
          hdr      = {hdr_shift, b};
          hdr_cnt  = 0;
          pts_word = hdr[95:32];
          len      = hdr[31:0];
          if (hdr[95]) begin
            // session packet: only bit 7 of byte 0 counts
            ev.kind         = KIND_SESSION;
            ev.frame_width  = hdr[63:32];
            ev.frame_height = hdr[31:0];
            expected_events.push_back(ev);
          end else if (len == 0) begin
            ev.kind = KIND_ERROR;
            expected_events.push_back(ev);
            ph = PH_HALT;
          end else begin
            held_cfg      = pts_word[CfgFlagBit];
            held_key      = pts_word[KeyFlagBit];
            held_ts       = held_cfg ? '0 : pts_word[TsBits-1:0];
            bytes_left    = len;
            first_pending = 1'b1;
            ph            = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        ev.kind            = KIND_PAYLOAD;
        ev.data_byte       = b;
        ev.first_of_packet = first_pending;
        ev.last_of_packet  = (bytes_left <= 1);
        ev.timestamp       = held_ts;
        ev.config_packet   = held_cfg;
        ev.is_key_frame    = held_key;
        expected_events.push_back(ev);
        first_pending = 1'b0;
        if (bytes_left <= 1) begin
          bytes_left = '0;
          hdr_cnt    = 0;
          ph         = PH_HEADER;
        end else begin
          bytes_left--;
        end
      end
      default: ;  // halted: byte dropped
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Link side
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (!steady && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Header goes out big-endian: byte 0 sits in the top bits.
  task automatic send_header(input logic [HdrBits-1:0] hdr);
    for (int i = HdrBytes - 1; i >= 0; i--) send_byte(hdr[i*8 +: 8]);
  endtask

  task automatic send_payload_packet(input logic [63:0] pts_word, input int unsigned len);
    send_header({pts_word, 32'(len)});
    repeat (len) send_byte(8'($urandom()));
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts unless in the steady stretch
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      if (!steady && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
  endtask

  // tdata: [7:0] byte, [68:8] timestamp, [69] config, [70] key,
  // [102:71] width, [134:103] height; tuser: [1:0] kind, [2] first
  always @(posedge clk) begin
    result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer, kind %0d", m_tuser[1:0]));
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 64'(m_tuser[1:0]), 64'(want.kind));
        check_field("data_byte", 64'(m_tdata[7:0]), 64'(want.data_byte));
        check_field("first_of_packet", 64'(m_tuser[2]), 64'(want.first_of_packet));
        check_field("last_of_packet", 64'(m_tlast), 64'(want.last_of_packet));
        check_field("timestamp", 64'(m_tdata[68:8]), 64'(want.timestamp));
        check_field("config_packet", 64'(m_tdata[69]), 64'(want.config_packet));
        check_field("is_key_frame", 64'(m_tdata[70]), 64'(want.is_key_frame));
        check_field("frame_width", 64'(m_tdata[102:71]), 64'(want.frame_width));
        check_field("frame_height", 64'(m_tdata[134:103]), 64'(want.frame_height));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Session header with every bit of bytes 0..3 set, extreme sizes.
  task automatic test_session_packet();
    send_header({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000});
  endtask

  // Config and key flags with all timestamp bits set; one byte is both
  // first and last, and the timestamp must read as zero.
  task automatic test_single_byte_payload();
    send_payload_packet(64'h7FFF_FFFF_FFFF_FFFF, 1);
  endtask

  // Mostly well-formed packets with random content, some session headers
  // with random bits, a few longer payloads.
  task automatic test_random_stream();
    logic [63:0]  pts_word;
    int unsigned  len;
    int unsigned  pick;
    while (bytes_sent < RandomBytes) begin
      if (bytes_sent + SteadyBytes >= RandomBytes) steady = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_header({1'b1, 31'($urandom()), 32'($urandom()), 32'($urandom())});
      end else begin
        pts_word     = {32'($urandom()), 32'($urandom())};
        pts_word[63] = 1'b0;
        if (pick < 90) len = $urandom_range(1, 16);
        else           len = $urandom_range(17, 300);
        send_payload_packet(pts_word, len);
      end
    end
  endtask

  // Zero length raises the error, then every byte is dropped.
  task automatic test_zero_length_halt();
    logic [63:0] pts_word;
    pts_word     = {32'($urandom()), 32'($urandom())};
    pts_word[63] = 1'b0;
    send_header({pts_word, 32'h0});
    send_header({1'b1, 31'($urandom()), 32'($urandom()), 32'($urandom())});
    repeat (6) send_byte(8'($urandom()));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_session_packet();
    test_single_byte_payload();
    test_random_stream();
    test_zero_length_halt();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
